>>> hw/rtl/mtrd_pkg.sv
// Package for the MT19937 ranged draw core: state encoding, table constants,
// tempering function. No dependencies.
`timescale 1ns / 1ps

package mtrd_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned IDX_W        = 10;
    localparam int unsigned WORD_W       = 32;

    localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] TWIST_IDX     = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0] UNSEEDED_IDX  = IDX_W'(STATE_WORDS + 1);
    localparam logic [IDX_W-1:0] OFFSET_IDX    = IDX_W'(TWIST_OFFSET);
    localparam logic [IDX_W-1:0] WRAP_IDX      = IDX_W'(STATE_WORDS - TWIST_OFFSET);

    localparam logic [WORD_W-1:0] SEED_RESET = 32'd4357;
    localparam logic [WORD_W-1:0] FILL_MULT  = 32'd69069;
    localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_TW_LOAD,
        ST_TW_CUR,
        ST_TW_NEXT,
        ST_TW_FAR,
        ST_TW_WRITE,
        ST_READ,
        ST_TEMPER,
        ST_DIV,
        ST_DELIVER
    } state_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> hw/rtl/mersenne_twister_ranged_draw_core.sv
// Top level of the MT19937 ranged draw core: sequencer, table RAM, output stage.
// Depends on mtrd_pkg, mtrd_ram and mtrd_divider.
//
//   channel  signals                      direction  payload
//   in       in_valid / in_stall           request    range_limit
//   out      out_valid / out_stall         result     random_value
//   cfg      cfg_valid / cfg_ready         write      seed
//
// A draw runs through RAM read, temper, the remainder unit and output load.
// A range of zero goes straight to delivery and leaves the generator alone.
// The first draw after reset or a seed write adds a fill of all 624 table words;
// every 624th nonzero draw adds a twist of the table through the one RAM.
// The table is undefined after reset; the first nonzero draw fills it.
// A result waiting on out_stall holds the output register; one more request may
// be taken meanwhile and waits before its own delivery.
`timescale 1ns / 1ps

module mersenne_twister_ranged_draw_core
    import mtrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [WORD_W-1:0] range_limit,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] random_value,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] seed
);

    state_t            state_reg;
    state_t            state_next;
    logic [WORD_W-1:0] seed_reg;
    logic [IDX_W-1:0]  read_idx_reg;
    logic [IDX_W-1:0]  read_idx_next;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  k_next;
    logic [WORD_W-1:0] range_reg;
    logic [WORD_W-1:0] fill_reg;
    logic [WORD_W-1:0] fill_next;
    logic [WORD_W-1:0] cur_reg;
    logic [WORD_W-1:0] nxt_reg;
    logic [WORD_W-1:0] res_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_rem;

    logic [IDX_W-1:0]  next_idx;
    logic [IDX_W-1:0]  far_idx;
    logic [WORD_W-1:0] twist_y;
    logic [WORD_W-1:0] twist_word;
    logic              in_accept;
    logic              cfg_accept;
    logic              out_free;

    mtrd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mtrd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (temper(ram_rdata)),
        .divisor   (range_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign in_accept  = in_valid && !in_stall;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || !out_stall;

    assign next_idx   = (k_reg == LAST_IDX) ? '0 : k_reg + IDX_W'(1);
    assign far_idx    = (k_reg < WRAP_IDX) ? k_reg + OFFSET_IDX : k_reg - WRAP_IDX;
    assign twist_y    = {cur_reg[WORD_W-1], nxt_reg[WORD_W-2:0]};
    assign twist_word = ram_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_XOR : '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (range_limit == '0)
                    begin
                        state_next = ST_DELIVER;
                    end
                    else if (read_idx_reg > TWIST_IDX)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (read_idx_reg == TWIST_IDX)
                    begin
                        state_next = ST_TW_LOAD;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FILL:
            begin
                if (k_reg == LAST_IDX)
                begin
                    state_next = ST_TW_LOAD;
                end
            end
            ST_TW_LOAD:  state_next = ST_TW_CUR;
            ST_TW_CUR:   state_next = ST_TW_NEXT;
            ST_TW_NEXT:  state_next = ST_TW_FAR;
            ST_TW_FAR:   state_next = ST_TW_WRITE;
            ST_TW_WRITE:
            begin
                state_next = (k_reg == LAST_IDX) ? ST_READ : ST_TW_NEXT;
            end
            ST_READ:     state_next = ST_TEMPER;
            ST_TEMPER:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        in_stall      = 1'b1;
        cfg_ready     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = k_reg;
        ram_wdata     = fill_reg;
        ram_raddr     = read_idx_reg;
        div_start     = 1'b0;
        k_next        = k_reg;
        fill_next     = fill_reg;
        read_idx_next = read_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = !in_valid;
                k_next    = '0;
                fill_next = seed_reg;
                if (cfg_accept)
                begin
                    read_idx_next = UNSEEDED_IDX;
                end
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                fill_next = WORD_W'(fill_reg * FILL_MULT);
                k_next    = (k_reg == LAST_IDX) ? '0 : k_reg + IDX_W'(1);
            end
            ST_TW_LOAD:
            begin
                ram_raddr = '0;
                k_next    = '0;
            end
            ST_TW_NEXT:
            begin
                ram_raddr = next_idx;
            end
            ST_TW_FAR:
            begin
                ram_raddr = far_idx;
            end
            ST_TW_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = twist_word;
                if (k_reg == LAST_IDX)
                begin
                    read_idx_next = '0;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_READ:
            begin
                ram_raddr = read_idx_reg;
            end
            ST_TEMPER:
            begin
                div_start     = 1'b1;
                read_idx_next = read_idx_reg + IDX_W'(1);
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= SEED_RESET;
            read_idx_reg  <= UNSEEDED_IDX;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            read_idx_reg <= read_idx_next;
            k_reg        <= k_next;
            if (cfg_accept)
            begin
                seed_reg <= seed;
            end
            if (state_reg == ST_DELIVER && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg <= fill_next;
        if (in_accept)
        begin
            range_reg <= range_limit;
            res_reg   <= '0;
        end
        if (state_reg == ST_TW_CUR)
        begin
            cur_reg <= ram_rdata;
        end
        if (state_reg == ST_TW_FAR)
        begin
            nxt_reg <= ram_rdata;
        end
        if (state_reg == ST_TW_WRITE)
        begin
            cur_reg <= nxt_reg;
        end
        if (div_done)
        begin
            res_reg <= div_rem;
        end
        if (state_reg == ST_DELIVER && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        read_idx_reg <= UNSEEDED_IDX)
        else $error("read index beyond unseeded mark");

    a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> read_idx_reg < TWIST_IDX)
        else $error("table read with index outside table");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("remainder ready outside divide state");

    a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER && range_reg == '0) |-> res_reg == '0)
        else $error("zero range gives nonzero result");

    a_twist_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_WRITE && k_reg == LAST_IDX) |=> read_idx_reg == '0)
        else $error("index not rewound after twist");

endmodule

>>> hw/rtl/mtrd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
`timescale 1ns / 1ps

module mtrd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/mtrd_divider.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Uses mtrd_pkg for the word width.
`timescale 1ns / 1ps

module mtrd_divider
    import mtrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(WORD_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [WORD_W-1:0] dvd_reg;
    logic [WORD_W-1:0] dvd_next;
    logic [WORD_W-1:0] dsr_reg;
    logic [WORD_W-1:0] dsr_next;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[WORD_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            if (!trial[WORD_W])
            begin
                rem_next = trial[WORD_W-1:0];
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
